// File: sv/wrss_pkg.sv
//------------------------------------------------------------------------------
// wrss_pkg
// Shared types and codes for the weighted random server select block.
//------------------------------------------------------------------------------
`default_nettype none

package wrss_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int ID_BITS  = 32;
  localparam int RND_BITS = 32;
  localparam int IW_BITS  = 16;

  localparam logic [1:0] CMD_CONNECT    = 2'd0;
  localparam logic [1:0] CMD_DISCONNECT = 2'd1;
  localparam logic [1:0] CMD_SET_WEIGHT = 2'd2;
  localparam logic [1:0] CMD_SELECT     = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NONE      = 2'd3;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [ID_BITS-1:0]  node_id;
    logic [IW_BITS-1:0]  weight_in;
    logic [RND_BITS-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_BITS-1:0] chosen_node;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: sv/wrss_cell.sv
//------------------------------------------------------------------------------
// wrss_cell
// One table entry: node id and weight, loaded directly or taken from the
// neighbor cell.
//------------------------------------------------------------------------------
`default_nettype none

module wrss_cell #(
  parameter int WEIGHT_BITS = wrss_pkg::WEIGHT_BITS_DEF
) (
  input  wire                              clk,
  input  wrss_pkg::cell_ctl_t              ctl,
  input  wire  [wrss_pkg::ID_BITS-1:0]     nb_id,
  input  wire  [WEIGHT_BITS-1:0]           nb_wt,
  input  wire  [wrss_pkg::ID_BITS-1:0]     ld_id,
  input  wire  [WEIGHT_BITS-1:0]           ld_wt,
  output logic [wrss_pkg::ID_BITS-1:0]     id_q,
  output logic [WEIGHT_BITS-1:0]           wt_q
);

  logic [wrss_pkg::ID_BITS-1:0] id_r;
  logic [WEIGHT_BITS-1:0]       wt_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r <= ld_id;
      wt_r <= ld_wt;
    end else if (ctl.shift) begin
      id_r <= nb_id;
      wt_r <= nb_wt;
    end
  end

  assign id_q = id_r;
  assign wt_q = wt_r;

endmodule

`default_nettype wire

// File: sv/weighted_random_server_select.sv
//------------------------------------------------------------------------------
// weighted_random_server_select
// Ordered server table with connect, disconnect, set weight and weighted
// random select, built on a ring of table cells.
//------------------------------------------------------------------------------
// usage
//   in channel: drive in_item and raise start; the item is taken at an edge
//   with start high and busy low. one result comes back on out_item, marked
//   by out_valid for exactly one cycle; the receiver cannot stall it.
//   cfg_we/cfg_wdata write initial_weight; the user must write it only while
//   the block is idle, the block itself does not enforce this.
// operation
//   connect answers without raising busy. disconnect and set weight rotate
//   the ring once to look up the entry; disconnect then compacts the table
//   when the entry was found. select rotates the cell ring once to sum the
//   weights, ending there when the total is zero; else it runs a one bit per
//   cycle remainder over the 32-bit random word, then rotates once more to
//   walk the entries. one item at a time, a new item may be taken in the
//   cycle its predecessor's result is shown.
// reset
//   rst_n low clears the entry count, initial_weight and the sequencer;
//   table contents are not cleared.
//------------------------------------------------------------------------------
`default_nettype none

module weighted_random_server_select #(
  parameter int MAX_ENTRIES = wrss_pkg::MAX_ENTRIES_DEF,
  parameter int WEIGHT_BITS = wrss_pkg::WEIGHT_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wrss_pkg::in_item_t                in_item,
  output logic                              out_valid,
  output wrss_pkg::out_item_t               out_item,
  input  wire                               cfg_we,
  input  wire  [wrss_pkg::IW_BITS-1:0]      cfg_wdata
);

  localparam int IDXW = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int TOTW = WEIGHT_BITS + CNTW;
  localparam int DCW  = $clog2(wrss_pkg::RND_BITS);
  localparam int IDB  = wrss_pkg::ID_BITS;
  localparam logic [32:0] WMAX = (33'd1 << WEIGHT_BITS) - 33'd1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_COMPACT = 6'b000100,
    S_SUM     = 6'b001000,
    S_DIV     = 6'b010000,
    S_WALK    = 6'b100000
  } state_t;

  function automatic logic [WEIGHT_BITS-1:0] sat_w(input logic [wrss_pkg::IW_BITS-1:0] v);
    logic [32:0] wide;
    wide = 33'(v);
    if (wide > WMAX) wide = WMAX;
    return wide[WEIGHT_BITS-1:0];
  endfunction

  state_t                         state_r, state_nxt;
  logic [CNTW-1:0]                count_r, count_nxt;
  logic [CNTW-1:0]                step_r, step_nxt;
  logic [DCW-1:0]                 dcnt_r, dcnt_nxt;
  logic                           found_r, found_nxt;
  logic [IDXW-1:0]                pos_r, pos_nxt;
  logic [IDB-1:0]                 chosen_r, chosen_nxt;
  logic [TOTW-1:0]                total_r, total_nxt;
  logic [TOTW-1:0]                rem_r, rem_nxt;
  logic [wrss_pkg::IW_BITS-1:0]   iw_r;
  logic [1:0]                     cmd_r, cmd_nxt;
  logic [IDB-1:0]                 id_r, id_nxt;
  logic [WEIGHT_BITS-1:0]         wt_r, wt_nxt;
  logic [wrss_pkg::RND_BITS-1:0]  rnd_r, rnd_nxt;
  logic                           out_valid_r, out_valid_nxt;
  wrss_pkg::out_item_t            out_r, out_nxt;

  wrss_pkg::cell_ctl_t            ctl [MAX_ENTRIES];
  logic [IDB-1:0]                 cell_id [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0]         cell_wt [MAX_ENTRIES];

  logic                           rotate, compact, ld_en;
  logic [IDXW-1:0]                ld_idx;
  logic [IDB-1:0]                 ld_id;
  logic [WEIGHT_BITS-1:0]         ld_wt;

  logic                           accept, in_range, step_last, match;
  logic [TOTW-1:0]                head_wt;
  logic [TOTW:0]                  rem_sh, tot_ext;

  assign accept    = start && state_r == S_IDLE;
  assign in_range  = step_r < count_r;
  assign step_last = step_r == CNTW'(MAX_ENTRIES - 1);
  assign head_wt   = TOTW'(cell_wt[0]);
  assign match     = in_range && !found_r && cell_id[0] == id_r;
  assign rem_sh    = {rem_r, rnd_r[wrss_pkg::RND_BITS-1]};
  assign tot_ext   = {1'b0, total_r};

  // ring of cells
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    localparam int NB = (g + 1) % MAX_ENTRIES;
    wrss_cell #(
      .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl[g]),
      .nb_id (cell_id[NB]),
      .nb_wt (cell_wt[NB]),
      .ld_id (ld_id),
      .ld_wt (ld_wt),
      .id_q  (cell_id[g]),
      .wt_q  (cell_wt[g])
    );
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctl[i].shift = rotate || (compact && IDXW'(i) >= pos_r);
      ctl[i].load  = ld_en && IDXW'(i) == ld_idx;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    dcnt_nxt      = dcnt_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    chosen_nxt    = chosen_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    wt_nxt        = wt_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rotate        = 1'b0;
    compact       = 1'b0;
    ld_en         = 1'b0;
    ld_idx        = count_r[IDXW-1:0];
    ld_id         = in_item.node_id;
    ld_wt         = sat_w(iw_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_item.cmd;
          id_nxt   = in_item.node_id;
          wt_nxt   = sat_w(in_item.weight_in);
          rnd_nxt  = in_item.random_word;
          step_nxt = '0;
          found_nxt = 1'b0;
          unique case (in_item.cmd) inside
            wrss_pkg::CMD_CONNECT: begin
              out_valid_nxt       = 1'b1;
              out_nxt.chosen_node = '0;
              if (count_r == CNTW'(MAX_ENTRIES)) begin
                out_nxt.status = wrss_pkg::STAT_FULL;
              end else begin
                ld_en          = 1'b1;
                count_nxt      = count_r + 1'b1;
                out_nxt.status = wrss_pkg::STAT_OK;
              end
            end
            wrss_pkg::CMD_DISCONNECT, wrss_pkg::CMD_SET_WEIGHT: begin
              state_nxt = S_SCAN;
            end
            wrss_pkg::CMD_SELECT: begin
              state_nxt = S_SUM;
              total_nxt = '0;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        rotate   = 1'b1;
        step_nxt = step_r + 1'b1;
        if (match) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r[IDXW-1:0];
          if (cmd_r == wrss_pkg::CMD_SET_WEIGHT) begin
            // head wraps to the tail carrying the new weight
            ld_en  = 1'b1;
            ld_idx = IDXW'(MAX_ENTRIES - 1);
            ld_id  = cell_id[0];
            ld_wt  = wt_r;
          end
        end
        if (step_last) begin
          out_nxt.chosen_node = '0;
          if (!found_nxt) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_nxt.status = wrss_pkg::STAT_NOT_FOUND;
          end else if (cmd_r == wrss_pkg::CMD_DISCONNECT) begin
            state_nxt = S_COMPACT;
          end else begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_nxt.status = wrss_pkg::STAT_OK;
          end
        end
      end
      S_COMPACT: begin
        compact             = 1'b1;
        count_nxt           = count_r - 1'b1;
        state_nxt           = S_IDLE;
        out_valid_nxt       = 1'b1;
        out_nxt.status      = wrss_pkg::STAT_OK;
        out_nxt.chosen_node = '0;
      end
      S_SUM: begin
        rotate   = 1'b1;
        step_nxt = step_r + 1'b1;
        if (in_range) total_nxt = total_r + head_wt;
        if (step_last) begin
          if (total_nxt == '0) begin
            state_nxt           = S_IDLE;
            out_valid_nxt       = 1'b1;
            out_nxt.status      = wrss_pkg::STAT_NONE;
            out_nxt.chosen_node = '0;
          end else begin
            state_nxt = S_DIV;
            dcnt_nxt  = '0;
            rem_nxt   = '0;
          end
        end
      end
      S_DIV: begin
        // restoring remainder, one random bit per cycle, msb first
        rem_nxt  = (rem_sh >= tot_ext) ? TOTW'(rem_sh - tot_ext) : TOTW'(rem_sh);
        rnd_nxt  = {rnd_r[wrss_pkg::RND_BITS-2:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(wrss_pkg::RND_BITS - 1)) begin
          state_nxt  = S_WALK;
          step_nxt   = '0;
          found_nxt  = 1'b0;
          chosen_nxt = '0;
        end
      end
      S_WALK: begin
        // draw = rem + 1, so draw <= w becomes rem < w
        rotate   = 1'b1;
        step_nxt = step_r + 1'b1;
        if (in_range && !found_r && head_wt != '0) begin
          if (rem_r < head_wt) begin
            found_nxt  = 1'b1;
            chosen_nxt = cell_id[0];
          end else begin
            rem_nxt = rem_r - head_wt;
          end
        end
        if (step_last) begin
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = wrss_pkg::STAT_OK;
          out_nxt.chosen_node = chosen_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iw_r        <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      dcnt_r      <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      dcnt_r      <= dcnt_nxt;
      found_r     <= found_nxt;
      if (cfg_we) iw_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    chosen_r <= chosen_nxt;
    total_r  <= total_nxt;
    rem_r    <= rem_nxt;
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    wt_r     <= wt_nxt;
    rnd_r    <= rnd_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// File: sv/wrss_checker.sv
//------------------------------------------------------------------------------
// wrss_checker
// Port level checks for the weighted random server select block.
//------------------------------------------------------------------------------
`default_nettype none

module wrss_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wrss_pkg::in_item_t  in_item,
  input wire                 out_valid,
  input wrss_pkg::out_item_t out_item
);

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy right after reset");

  // a result is only shown once the block is free again
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // busy ends with a result
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  // connect answers in the next cycle
  a_connect_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.cmd == wrss_pkg::CMD_CONNECT |=> out_valid)
    else $error("connect result late");

  // failed commands carry no node
  a_zero_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != wrss_pkg::STAT_OK |-> out_item.chosen_node == '0)
    else $error("node reported on failed item");

endmodule

bind weighted_random_server_select wrss_checker u_wrss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire
